/* hw/rtl/q24_8_fixed_point_alu_core_defines.svh */
// Assertion macros used by the checker of the fixed-point ALU.
// Each macro takes a label, a clock, a reset, an antecedent, a consequent and a message.
`ifndef Q24_8_FIXED_POINT_ALU_CORE_DEFINES_SVH
`define Q24_8_FIXED_POINT_ALU_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define Q24ALU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define Q24ALU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/q24alu_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Word types, operation codes, payload structs and the saturation helper.
// ----------------------------------------------------------------------------
package q24alu_pkg;

   localparam int WORD_WIDTH        = 32;
   localparam int MAG_WIDTH         = 64;
   localparam int FRAC_BITS_DEFAULT = 8;

   typedef logic [WORD_WIDTH-1:0]        word_type;
   typedef logic signed [WORD_WIDTH-1:0] sword_type;
   typedef logic [MAG_WIDTH-1:0]         mag_type;

   localparam word_type POS_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type NEG_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   typedef enum logic [3:0] {
      MODE_ADD      = 4'd0,
      MODE_SUB      = 4'd1,
      MODE_MUL      = 4'd2,
      MODE_DIV      = 4'd3,
      MODE_MIN      = 4'd4,
      MODE_MAX      = 4'd5,
      MODE_INC      = 4'd6,
      MODE_DEC      = 4'd7,
      MODE_TO_FIXED = 4'd8,
      MODE_TO_INT   = 4'd9
   } mode_type;

   typedef struct packed {
      logic [3:0] mode;
      sword_type  operand_a;
      sword_type  operand_b;
   } req_payload_type;

   typedef struct packed {
      sword_type result;
      logic      less;
      logic      equal;
      logic      greater;
      logic      overflow;
      logic      divide_by_zero;
   } rsp_payload_type;

   typedef struct packed {
      logic [3:0] mode;
      sword_type  res;
      logic       ovf;
      logic       dz;
      logic       neg;
      logic       less;
      logic       equal;
      logic       greater;
   } cell_info_type;

   // Saturates a magnitude with a sign to the word range. Returns {overflow, word}.
   function automatic logic [WORD_WIDTH:0] sat_pack(input logic neg, input mag_type mag);
      mag_type  lim;
      word_type low;
      lim = neg ? {{(MAG_WIDTH-WORD_WIDTH){1'b0}}, NEG_MIN}
                : {{(MAG_WIDTH-WORD_WIDTH){1'b0}}, POS_MAX};
      low = mag[WORD_WIDTH-1:0];
      if (mag > lim) begin
         sat_pack = {1'b1, lim[WORD_WIDTH-1:0]};
      end else begin
         sat_pack = {1'b0, neg ? (~low + 1'b1) : low};
      end
   endfunction

endpackage

/* hw/rtl/q24alu_chan_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload per transfer from a source to a sink.
// ----------------------------------------------------------------------------
interface q24alu_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/q24_8_fixed_point_alu_core.sv */
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU core
// Add, subtract, multiply, divide, min, max, step and format conversions on
// signed fixed-point words, saturating with an overflow flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                                     Transfer
//  req_if    in         mode, operand_a, operand_b                  valid && ready
//  rsp_if    out        result, less, equal, greater, overflow,     valid && ready
//                       divide_by_zero
//
//  One item is accepted per cycle while req_if.ready is high; each result
//  passes through three front stages, the row of WORD_WIDTH + FRAC_BITS
//  divider cells and the output register before it is valid on rsp_if.
//  Reset is synchronous and empties every stage and the output register.
//  A stalled result leaves room for one more in the skid entry, after which
//  the whole row holds and req_if.ready falls until the result is taken.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu_core #(
   parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   q24alu_chan_if.sink   req_if,
   q24alu_chan_if.source rsp_if
);

   localparam int QUOT_WIDTH = q24alu_pkg::WORD_WIDTH + FRAC_BITS;

   logic                      advance;
   logic [QUOT_WIDTH:0]       chain_valid;
   q24alu_pkg::cell_info_type chain_info    [QUOT_WIDTH+1];
   q24alu_pkg::word_type      chain_rem     [QUOT_WIDTH+1];
   logic [QUOT_WIDTH-1:0]     chain_work    [QUOT_WIDTH+1];
   q24alu_pkg::word_type      chain_divisor [QUOT_WIDTH+1];

   assign req_if.ready = advance;
   assign chain_rem[0] = '0;

   q24alu_front #(
      .FRAC_BITS  (FRAC_BITS),
      .QUOT_WIDTH (QUOT_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_valid   (req_if.valid),
      .req_payload (req_if.payload),
      .out_valid   (chain_valid[0]),
      .out_info    (chain_info[0]),
      .out_work    (chain_work[0]),
      .out_divisor (chain_divisor[0])
   );

   for (genvar i = 0; i < QUOT_WIDTH; i++) begin : g_cell
      q24alu_cell #(
         .QUOT_WIDTH (QUOT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .in_valid    (chain_valid[i]),
         .in_info     (chain_info[i]),
         .in_rem      (chain_rem[i]),
         .in_work     (chain_work[i]),
         .in_divisor  (chain_divisor[i]),
         .out_valid   (chain_valid[i+1]),
         .out_info    (chain_info[i+1]),
         .out_rem     (chain_rem[i+1]),
         .out_work    (chain_work[i+1]),
         .out_divisor (chain_divisor[i+1])
      );
   end

   q24alu_back #(
      .QUOT_WIDTH (QUOT_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (chain_valid[QUOT_WIDTH]),
      .in_info     (chain_info[QUOT_WIDTH]),
      .in_work     (chain_work[QUOT_WIDTH]),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_payload (rsp_if.payload),
      .advance     (advance)
   );

endmodule

/* hw/rtl/q24alu_front.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Three stages: operand magnitudes and compares, the product, and the
// results of all modes except the quotient, which it hands to the divider cells.
// ----------------------------------------------------------------------------
module q24alu_front #(
   parameter int FRAC_BITS  = q24alu_pkg::FRAC_BITS_DEFAULT,
   parameter int QUOT_WIDTH = q24alu_pkg::WORD_WIDTH + FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        req_valid,
   input  q24alu_pkg::req_payload_type req_payload,
   output logic                        out_valid,
   output q24alu_pkg::cell_info_type   out_info,
   output logic [QUOT_WIDTH-1:0]       out_work,
   output q24alu_pkg::word_type        out_divisor
);

   typedef struct packed {
      logic [3:0]            mode;
      q24alu_pkg::sword_type opa;
      q24alu_pkg::sword_type opb;
      logic                  na;
      logic                  nb;
      q24alu_pkg::word_type  ma;
      q24alu_pkg::word_type  mb;
      logic                  less;
      logic                  equal;
      logic                  greater;
   } operand_type;

   logic                       a_valid_ff, a_valid_in;
   operand_type                a_ff, a_in;
   logic                       b_valid_ff, b_valid_in;
   operand_type                b_ff;
   q24alu_pkg::mag_type        b_prod_ff, b_prod_in;
   logic                       c_valid_ff, c_valid_in;
   q24alu_pkg::cell_info_type  c_info_ff, c_info_in;
   logic [QUOT_WIDTH-1:0]      c_work_ff, c_work_in;
   q24alu_pkg::word_type       c_divisor_ff, c_divisor_in;

   logic [q24alu_pkg::WORD_WIDTH:0] add_y, add_sum;
   logic                            add_c, add_ovf;
   logic [q24alu_pkg::WORD_WIDTH:0] mul_sat, fix_sat;

   always_comb begin
      a_valid_in  = req_valid;
      a_in.mode   = req_payload.mode;
      a_in.opa    = req_payload.operand_a;
      a_in.opb    = req_payload.operand_b;
      a_in.na     = req_payload.operand_a[q24alu_pkg::WORD_WIDTH-1];
      a_in.nb     = req_payload.operand_b[q24alu_pkg::WORD_WIDTH-1];
      a_in.ma     = a_in.na ? (~req_payload.operand_a + 1'b1) : req_payload.operand_a;
      a_in.mb     = a_in.nb ? (~req_payload.operand_b + 1'b1) : req_payload.operand_b;
      a_in.less    = req_payload.operand_a < req_payload.operand_b;
      a_in.equal   = req_payload.operand_a == req_payload.operand_b;
      a_in.greater = req_payload.operand_a > req_payload.operand_b;
   end

   assign b_valid_in = a_valid_ff;
   assign b_prod_in  = a_ff.ma * a_ff.mb;

   always_comb begin
      add_y = '0;
      add_c = 1'b0;
      unique case (q24alu_pkg::mode_type'(b_ff.mode))
         q24alu_pkg::MODE_ADD: begin
            add_y = {b_ff.opb[q24alu_pkg::WORD_WIDTH-1], b_ff.opb};
         end
         q24alu_pkg::MODE_SUB: begin
            add_y = ~{b_ff.opb[q24alu_pkg::WORD_WIDTH-1], b_ff.opb};
            add_c = 1'b1;
         end
         q24alu_pkg::MODE_INC: begin
            add_c = 1'b1;
         end
         q24alu_pkg::MODE_DEC: begin
            add_y = '1;
         end
         default: begin
         end
      endcase
   end

   assign add_sum = {b_ff.opa[q24alu_pkg::WORD_WIDTH-1], b_ff.opa} + add_y
                    + {{q24alu_pkg::WORD_WIDTH{1'b0}}, add_c};
   assign add_ovf = add_sum[q24alu_pkg::WORD_WIDTH] ^ add_sum[q24alu_pkg::WORD_WIDTH-1];
   assign mul_sat = q24alu_pkg::sat_pack(b_ff.na ^ b_ff.nb, b_prod_ff >> FRAC_BITS);
   assign fix_sat = q24alu_pkg::sat_pack(b_ff.na,
      {{(q24alu_pkg::MAG_WIDTH-q24alu_pkg::WORD_WIDTH){1'b0}}, b_ff.ma} << FRAC_BITS);

   always_comb begin
      c_valid_in        = b_valid_ff;
      c_info_in         = '0;
      c_info_in.mode    = b_ff.mode;
      c_info_in.less    = b_ff.less;
      c_info_in.equal   = b_ff.equal;
      c_info_in.greater = b_ff.greater;
      c_info_in.neg     = b_ff.na ^ b_ff.nb;
      c_work_in         = {b_ff.ma, {FRAC_BITS{1'b0}}};
      c_divisor_in      = b_ff.mb;
      unique case (q24alu_pkg::mode_type'(b_ff.mode))
         q24alu_pkg::MODE_ADD, q24alu_pkg::MODE_SUB,
         q24alu_pkg::MODE_INC, q24alu_pkg::MODE_DEC: begin
            c_info_in.ovf = add_ovf;
            if (add_ovf) begin
               c_info_in.res = add_sum[q24alu_pkg::WORD_WIDTH] ? q24alu_pkg::NEG_MIN
                                                               : q24alu_pkg::POS_MAX;
            end else begin
               c_info_in.res = add_sum[q24alu_pkg::WORD_WIDTH-1:0];
            end
         end
         q24alu_pkg::MODE_MUL: begin
            {c_info_in.ovf, c_info_in.res} = mul_sat;
         end
         q24alu_pkg::MODE_DIV: begin
            if (b_ff.mb == '0) begin
               c_info_in.dz  = 1'b1;
               c_info_in.ovf = 1'b1;
               c_info_in.res = b_ff.na ? q24alu_pkg::NEG_MIN : q24alu_pkg::POS_MAX;
            end
         end
         q24alu_pkg::MODE_MIN: begin
            c_info_in.res = b_ff.less ? b_ff.opa : b_ff.opb;
         end
         q24alu_pkg::MODE_MAX: begin
            c_info_in.res = b_ff.greater ? b_ff.opa : b_ff.opb;
         end
         q24alu_pkg::MODE_TO_FIXED: begin
            {c_info_in.ovf, c_info_in.res} = fix_sat;
         end
         q24alu_pkg::MODE_TO_INT: begin
            c_info_in.res = $signed(b_ff.opa) >>> FRAC_BITS;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff         <= a_in;
         b_ff         <= a_ff;
         b_prod_ff    <= b_prod_in;
         c_info_ff    <= c_info_in;
         c_work_ff    <= c_work_in;
         c_divisor_ff <= c_divisor_in;
      end
   end

   assign out_valid   = c_valid_ff;
   assign out_info    = c_info_ff;
   assign out_work    = c_work_ff;
   assign out_divisor = c_divisor_ff;

endmodule

/* hw/rtl/q24alu_cell.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step on each item, passed on each cycle that advance is high.
// ----------------------------------------------------------------------------
module q24alu_cell #(
   parameter int QUOT_WIDTH = q24alu_pkg::WORD_WIDTH + q24alu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  q24alu_pkg::cell_info_type in_info,
   input  q24alu_pkg::word_type      in_rem,
   input  logic [QUOT_WIDTH-1:0]     in_work,
   input  q24alu_pkg::word_type      in_divisor,
   output logic                      out_valid,
   output q24alu_pkg::cell_info_type out_info,
   output q24alu_pkg::word_type      out_rem,
   output logic [QUOT_WIDTH-1:0]     out_work,
   output q24alu_pkg::word_type      out_divisor
);

   logic                            valid_ff;
   q24alu_pkg::cell_info_type       info_ff;
   q24alu_pkg::word_type            rem_ff, rem_in;
   logic [QUOT_WIDTH-1:0]           work_ff, work_in;
   q24alu_pkg::word_type            divisor_ff;
   q24alu_pkg::word_type            shifted;
   logic [q24alu_pkg::WORD_WIDTH:0] trial;
   logic                            qbit;

   // The remainder stays below the divisor, so its top bit is always clear.
   assign shifted = {in_rem[q24alu_pkg::WORD_WIDTH-2:0], in_work[QUOT_WIDTH-1]};
   assign trial   = {1'b0, shifted} - {1'b0, in_divisor};
   assign qbit    = !trial[q24alu_pkg::WORD_WIDTH];
   assign rem_in  = qbit ? trial[q24alu_pkg::WORD_WIDTH-1:0] : shifted;
   assign work_in = {in_work[QUOT_WIDTH-2:0], qbit};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         info_ff    <= in_info;
         rem_ff     <= rem_in;
         work_ff    <= work_in;
         divisor_ff <= in_divisor;
      end
   end

   assign out_valid   = valid_ff;
   assign out_info    = info_ff;
   assign out_rem     = rem_ff;
   assign out_work    = work_ff;
   assign out_divisor = divisor_ff;

endmodule

/* hw/rtl/q24alu_back.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Saturates the quotient, picks the final result and holds it in an output
// register with a skid entry behind it.
// ----------------------------------------------------------------------------
module q24alu_back #(
   parameter int QUOT_WIDTH = q24alu_pkg::WORD_WIDTH + q24alu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  q24alu_pkg::cell_info_type   in_info,
   input  logic [QUOT_WIDTH-1:0]       in_work,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output q24alu_pkg::rsp_payload_type rsp_payload,
   output logic                        advance
);

   logic                            out_valid_ff, out_valid_in;
   q24alu_pkg::rsp_payload_type     out_ff, out_in;
   logic                            skid_valid_ff, skid_valid_in;
   q24alu_pkg::rsp_payload_type     skid_ff, skid_in;
   q24alu_pkg::rsp_payload_type     fresh;
   logic [q24alu_pkg::WORD_WIDTH:0] div_sat;
   logic                            take, push;

   assign div_sat = q24alu_pkg::sat_pack(in_info.neg,
      {{(q24alu_pkg::MAG_WIDTH-QUOT_WIDTH){1'b0}}, in_work});

   always_comb begin
      fresh.less           = in_info.less;
      fresh.equal          = in_info.equal;
      fresh.greater        = in_info.greater;
      fresh.divide_by_zero = in_info.dz;
      if (in_info.mode == q24alu_pkg::MODE_DIV && !in_info.dz) begin
         {fresh.overflow, fresh.result} = div_sat;
      end else begin
         fresh.overflow = in_info.ovf;
         fresh.result   = in_info.res;
      end
   end

   assign advance = !skid_valid_ff;
   assign take    = out_valid_ff && rsp_ready;
   assign push    = in_valid && advance;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = push;
         out_in       = fresh;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

/* hw/rtl/q24alu_checker.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Watches the result channel of the core and is bound to its top level.
// ----------------------------------------------------------------------------
`include "q24_8_fixed_point_alu_core_defines.svh"

module q24alu_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input q24alu_pkg::rsp_payload_type rsp_payload
);

   `Q24ALU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "Result dropped before its transfer.")
   `Q24ALU_ASSERT_NOW(a_cmp_onehot, clock, reset, rsp_valid, $onehot({rsp_payload.less, rsp_payload.equal, rsp_payload.greater}), "Compare flags are not exactly one.")
   `Q24ALU_ASSERT_NOW(a_dz_ovf, clock, reset, rsp_valid && rsp_payload.divide_by_zero, rsp_payload.overflow, "Divide by zero without overflow.")
   `Q24ALU_ASSERT_NOW(a_ovf_sat, clock, reset, rsp_valid && rsp_payload.overflow, rsp_payload.result == q24alu_pkg::POS_MAX || rsp_payload.result == q24alu_pkg::NEG_MIN, "Overflow result is not a range bound.")

endmodule

bind q24_8_fixed_point_alu_core q24alu_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);

/* tb/sv/q24_8_fixed_point_alu_core_tb.sv */
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU core testbench
// Drives operations through the request channel with random gaps and receiver
// stalls. A behavioral predictor computes each expected result exactly. A
// scoreboard compares every result transfer, field by field, in order.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC    = q24alu_pkg::FRAC_BITS_DEFAULT;
   localparam int LATENCY = FRAC + 36;

   localparam logic [3:0] MODE_UNUSED_FIRST = 4'd10;
   localparam logic [3:0] MODE_UNUSED_LAST  = 4'd15;

   localparam logic signed [71:0] WIDE_MAX = 72'sh0_7FFF_FFFF;
   localparam logic signed [71:0] WIDE_MIN = -72'sh0_8000_0000;

   logic clock;
   logic reset;

   q24alu_chan_if #(.payload_type(q24alu_pkg::req_payload_type)) req_if ();
   q24alu_chan_if #(.payload_type(q24alu_pkg::rsp_payload_type)) rsp_if ();

   q24_8_fixed_point_alu_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   q24alu_pkg::rsp_payload_type pending_results[$];
   int idle_pct      = 24;
   int stall_request = 0;
   int stall_left    = 0;
   int error_count   = 0;
   int sent_count    = 0;
   int checked_count = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2ms;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic q24alu_pkg::rsp_payload_type predict_alu(
      q24alu_pkg::req_payload_type item);
      q24alu_pkg::rsp_payload_type r;
      logic signed [71:0] wa;
      logic signed [71:0] wb;
      logic signed [71:0] exact;
      logic [71:0]        ma;
      logic [71:0]        mb;
      logic [71:0]        quot;
      logic               neg;
      logic               zero_div;
      r        = '0;
      wa       = item.operand_a;
      wb       = item.operand_b;
      ma       = (wa < 0) ? -wa : wa;
      mb       = (wb < 0) ? -wb : wb;
      neg      = (wa < 0) != (wb < 0);
      exact    = '0;
      zero_div = 1'b0;
      r.less    = item.operand_a < item.operand_b;
      r.equal   = item.operand_a == item.operand_b;
      r.greater = item.operand_a > item.operand_b;
      case (item.mode)
         q24alu_pkg::MODE_ADD: exact = wa + wb;
         q24alu_pkg::MODE_SUB: exact = wa - wb;
         q24alu_pkg::MODE_MUL: begin
            quot  = (ma * mb) >> FRAC;
            exact = neg ? -$signed(quot) : $signed(quot);
         end
         q24alu_pkg::MODE_DIV: begin
            if (mb == 0) begin
               zero_div = 1'b1;
            end else begin
               quot  = (ma << FRAC) / mb;
               exact = neg ? -$signed(quot) : $signed(quot);
            end
         end
         q24alu_pkg::MODE_MIN: exact = (wa < wb) ? wa : wb;
         q24alu_pkg::MODE_MAX: exact = (wa > wb) ? wa : wb;
         q24alu_pkg::MODE_INC: exact = wa + 1;
         q24alu_pkg::MODE_DEC: exact = wa - 1;
         q24alu_pkg::MODE_TO_FIXED: exact = wa <<< FRAC;
         q24alu_pkg::MODE_TO_INT: exact = wa >>> FRAC;
         default: exact = '0;
      endcase
      if (zero_div) begin
         r.divide_by_zero = 1'b1;
         r.overflow       = 1'b1;
         r.result         = (wa < 0) ? q24alu_pkg::NEG_MIN : q24alu_pkg::POS_MAX;
      end else if (exact > WIDE_MAX) begin
         r.overflow = 1'b1;
         r.result   = q24alu_pkg::POS_MAX;
      end else if (exact < WIDE_MIN) begin
         r.overflow = 1'b1;
         r.result   = q24alu_pkg::NEG_MIN;
      end else begin
         r.result = exact[q24alu_pkg::WORD_WIDTH-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         pending_results.push_back(predict_alu(req_if.payload));
         sent_count++;
      end
   end

   always @(posedge clock) begin
      q24alu_pkg::rsp_payload_type want;
      q24alu_pkg::rsp_payload_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", got.result, '0);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (got.result !== want.result)
               report_mismatch("result", got.result, want.result);
            if (got.less !== want.less)
               report_mismatch("less", 32'(got.less), 32'(want.less));
            if (got.equal !== want.equal)
               report_mismatch("equal", 32'(got.equal), 32'(want.equal));
            if (got.greater !== want.greater)
               report_mismatch("greater", 32'(got.greater), 32'(want.greater));
            if (got.overflow !== want.overflow)
               report_mismatch("overflow", 32'(got.overflow), 32'(want.overflow));
            if (got.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", 32'(got.divide_by_zero),
                               32'(want.divide_by_zero));
         end
      end
   end

   always @(posedge clock) begin
      if (stall_request > 0) begin
         stall_left    = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic send_item(input logic [3:0] mode, input q24alu_pkg::sword_type a,
                            input q24alu_pkg::sword_type b);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{mode: mode, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   function automatic q24alu_pkg::sword_type pick_operand();
      q24alu_pkg::sword_type v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom;
         4, 5: v = $signed($urandom_range(4095)) - 2048;
         6: begin
            case ($urandom_range(6))
               0: v = '0;
               1: v = 32'sd1;
               2: v = -32'sd1;
               3: v = q24alu_pkg::POS_MAX;
               4: v = q24alu_pkg::NEG_MIN;
               5: v = 32'sd256;
               default: v = -32'sd256;
            endcase
         end
         default: v = $signed($urandom_range(2097151)) - 1048576;
      endcase
      return v;
   endfunction

   task automatic test_directed_cases();
      send_item(q24alu_pkg::MODE_ADD, q24alu_pkg::POS_MAX, 32'sd1);
      send_item(q24alu_pkg::MODE_ADD, q24alu_pkg::NEG_MIN, -32'sd1);
      send_item(q24alu_pkg::MODE_SUB, '0, q24alu_pkg::NEG_MIN);
      send_item(q24alu_pkg::MODE_MUL, q24alu_pkg::POS_MAX, q24alu_pkg::POS_MAX);
      send_item(q24alu_pkg::MODE_MUL, q24alu_pkg::NEG_MIN, q24alu_pkg::POS_MAX);
      send_item(q24alu_pkg::MODE_MUL, -32'sd1, 32'sd1);
      send_item(q24alu_pkg::MODE_MUL, -32'sd640, 32'sd384);
      send_item(q24alu_pkg::MODE_DIV, 32'sd256, '0);
      send_item(q24alu_pkg::MODE_DIV, -32'sd256, '0);
      send_item(q24alu_pkg::MODE_DIV, '0, '0);
      send_item(q24alu_pkg::MODE_DIV, q24alu_pkg::NEG_MIN, -32'sd1);
      send_item(q24alu_pkg::MODE_DIV, 32'sd256, 32'sd768);
      send_item(q24alu_pkg::MODE_DIV, -32'sd1792, 32'sd512);
      send_item(q24alu_pkg::MODE_MIN, 32'sd77, 32'sd77);
      send_item(q24alu_pkg::MODE_MAX, q24alu_pkg::NEG_MIN, q24alu_pkg::POS_MAX);
      send_item(q24alu_pkg::MODE_INC, q24alu_pkg::POS_MAX, '0);
      send_item(q24alu_pkg::MODE_DEC, q24alu_pkg::NEG_MIN, '0);
      send_item(q24alu_pkg::MODE_DEC, '0, 32'sd9);
      send_item(q24alu_pkg::MODE_TO_FIXED, 32'sd8388607, '0);
      send_item(q24alu_pkg::MODE_TO_FIXED, 32'sd8388608, '0);
      send_item(q24alu_pkg::MODE_TO_FIXED, q24alu_pkg::NEG_MIN, '0);
      send_item(q24alu_pkg::MODE_TO_INT, -32'sd1, '0);
      send_item(q24alu_pkg::MODE_TO_INT, q24alu_pkg::NEG_MIN, q24alu_pkg::POS_MAX);
      send_item(MODE_UNUSED_FIRST, 32'sd5, -32'sd5);
      send_item(MODE_UNUSED_LAST, -32'sd5, -32'sd5);
   endtask

   task automatic test_random_mix(input int count);
      logic [3:0]            mode;
      q24alu_pkg::sword_type a;
      q24alu_pkg::sword_type b;
      repeat (count) begin
         if ($urandom_range(19) == 0)
            mode = 4'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
         else
            mode = 4'($urandom_range(q24alu_pkg::MODE_ADD, q24alu_pkg::MODE_TO_INT));
         a = pick_operand();
         b = ($urandom_range(15) == 0) ? a : pick_operand();
         send_item(mode, a, b);
      end
   endtask

   task automatic test_output_stall();
      idle_pct      = 0;
      stall_request = 400;
      test_random_mix(120);
      idle_pct = 24;
   endtask

   task automatic test_no_idle_stretch();
      idle_pct = 0;
      test_random_mix(300);
      idle_pct = 24;
   endtask

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_mix(350);
      test_no_idle_stretch();
      test_output_stall();
      test_random_mix(300);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3 * LATENCY) @(posedge clock);
      $display("Covered all ten operations, the unused codes, saturation and divide by zero.");
      $display("%0d operations sent, %0d results compared, %0d mismatches.",
               sent_count, checked_count, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
